// ===== rtl/core/dsap_pkg.sv =====
// dsap_pkg: shared types and constants of the drop shadow alpha pixel block
// no dependencies; used by every file in rtl/core
package dsap_pkg;

    localparam int PX_W    = 12;
    localparam int ALPHA_W = 8;
    localparam int SIZE_W  = 12;
    localparam int BYTE_W  = 8;

    localparam int CW   = PX_W + 1;
    localparam int SQ_W = 2 * CW + 1;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IX_W = 3;

    localparam logic [REG_IX_W-1:0] REG_POPUP_WIDTH  = 3'd0;
    localparam logic [REG_IX_W-1:0] REG_POPUP_HEIGHT = 3'd1;
    localparam logic [REG_IX_W-1:0] REG_MARGIN       = 3'd2;
    localparam logic [REG_IX_W-1:0] REG_OFFSET_X     = 3'd3;
    localparam logic [REG_IX_W-1:0] REG_OFFSET_Y     = 3'd4;
    localparam logic [REG_IX_W-1:0] REG_RADIUS       = 3'd5;
    localparam logic [REG_IX_W-1:0] REG_MAX_ALPHA    = 3'd6;

    localparam logic [SIZE_W-1:0] RST_POPUP_WIDTH  = 12'd1;
    localparam logic [SIZE_W-1:0] RST_POPUP_HEIGHT = 12'd1;
    localparam logic [BYTE_W-1:0] RST_MARGIN       = 8'd12;
    localparam logic [BYTE_W-1:0] RST_OFFSET_X     = 8'd2;
    localparam logic [BYTE_W-1:0] RST_OFFSET_Y     = 8'd4;
    localparam logic [BYTE_W-1:0] RST_RADIUS       = 8'd14;
    localparam logic [BYTE_W-1:0] RST_MAX_ALPHA    = 8'd58;

    typedef struct packed {
        logic [SIZE_W-1:0] popup_width;
        logic [SIZE_W-1:0] popup_height;
        logic [BYTE_W-1:0] margin;
        logic [BYTE_W-1:0] offset_x;
        logic [BYTE_W-1:0] offset_y;
        logic [BYTE_W-1:0] radius;
        logic [BYTE_W-1:0] max_alpha;
    } cfg_t;

    typedef struct packed {
        logic vld;
        logic zero;
    } ctl_t;

endpackage

// ===== rtl/core/dsap_pix_if.sv =====
// dsap_pix_if: pixel coordinate channel, valid/ready handshake
// depends on dsap_pkg
interface dsap_pix_if;
    logic                       valid;
    logic                       ready;
    logic [dsap_pkg::PX_W-1:0]  px;
    logic [dsap_pkg::PX_W-1:0]  py;

    modport source (output valid, output px, output py, input ready);
    modport sink (input valid, input px, input py, output ready);
endinterface

// ===== rtl/core/dsap_alpha_if.sv =====
// dsap_alpha_if: shadow alpha channel, valid/ready handshake
// depends on dsap_pkg
interface dsap_alpha_if;
    logic                         valid;
    logic                         ready;
    logic [dsap_pkg::ALPHA_W-1:0] alpha;

    modport source (output valid, output alpha, input ready);
    modport sink (input valid, input alpha, output ready);
endinterface

// ===== rtl/core/drop_shadow_alpha_pixel.sv =====
// drop_shadow_alpha_pixel: top level, shadow alpha for one pixel coordinate per word
// depends on dsap_pkg, dsap_pix_if, dsap_alpha_if, dsap_cfg, dsap_front,
// dsap_sqrt_cell, dsap_falloff, dsap_div_cell
//
//  channel  dir  handshake      payload
//  pix      in   valid/ready    px[11:0], py[11:0]
//  alp      out  valid/ready    alpha[7:0]
//  apb      in   psel/penable   paddr[4:0], pwdata/prdata[31:0], pready tied high
//
//  one word accepted per cycle while pix.ready is high; the path runs through the
//  front stages, the square root cell row, the falloff stages and the divide cell row
//  a two word output buffer takes the row's result; the row moves only while
//  the buffer has room, and pix.ready is low only when both words are held
//  reset empties the row and the buffer and loads the register defaults
module drop_shadow_alpha_pixel #(
    parameter int MAX_COORD = 4096,
    parameter int FRAC_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsap_pkg::ADDR_W-1:0]   paddr,
    input  logic [dsap_pkg::DATA_W-1:0]   pwdata,
    output logic [dsap_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    dsap_pix_if.sink                      pix,
    dsap_alpha_if.source                  alp
);

    localparam int NB  = (dsap_pkg::SQ_W + 1) / 2 + FRAC_BITS;
    localparam int DW  = dsap_pkg::BYTE_W + FRAC_BITS;
    localparam int NW  = 2 * DW + dsap_pkg::ALPHA_W;
    localparam int QW  = dsap_pkg::ALPHA_W;
    localparam int NQ  = dsap_pkg::ALPHA_W;

    dsap_pkg::cfg_t        cfg;
    logic                  en;
    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;
    logic [QW-1:0]         buf0_reg, buf1_reg;
    logic [QW-1:0]         res;
    logic                  push, pop;

    dsap_pkg::ctl_t              front_ctl;
    logic [dsap_pkg::SQ_W-1:0]   sq;

    dsap_pkg::ctl_t    sc_ctl  [0:NB];
    logic [2*NB-1:0]   sc_rad  [0:NB];
    logic [NB+1:0]     sc_rem  [0:NB];
    logic [NB-1:0]     sc_root [0:NB];

    dsap_pkg::ctl_t    fo_ctl;
    logic [NW-1:0]     num;
    logic [2*DW-1:0]   den;

    dsap_pkg::ctl_t    dc_ctl [0:NQ];
    logic [NW-1:0]     dc_p   [0:NQ];
    logic [QW-1:0]     dc_q   [0:NQ];

    dsap_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en        = cnt_reg != 2'd2;
    assign pix.ready = en;

    dsap_front #(.MAX_COORD(MAX_COORD)) u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (pix.valid),
        .px      (pix.px),
        .py      (pix.py),
        .cfg     (cfg),
        .ctl_out (front_ctl),
        .sq      (sq)
    );

    assign sc_ctl[0]  = front_ctl;
    assign sc_rad[0]  = (2*NB)'(sq) << (2 * FRAC_BITS);
    assign sc_rem[0]  = '0;
    assign sc_root[0] = '0;

    for (genvar i = 0; i < NB; i++)
    begin : g_sqrt
        dsap_sqrt_cell #(.NB(NB)) u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (sc_ctl[i]),
            .rad_in   (sc_rad[i]),
            .rem_in   (sc_rem[i]),
            .root_in  (sc_root[i]),
            .ctl_out  (sc_ctl[i+1]),
            .rad_out  (sc_rad[i+1]),
            .rem_out  (sc_rem[i+1]),
            .root_out (sc_root[i+1])
        );
    end

    dsap_falloff #(.FRAC_BITS(FRAC_BITS), .NB(NB)) u_falloff
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (sc_ctl[NB]),
        .d         (sc_root[NB]),
        .radius    (cfg.radius),
        .max_alpha (cfg.max_alpha),
        .ctl_out   (fo_ctl),
        .num       (num),
        .den       (den)
    );

    assign dc_ctl[0] = fo_ctl;
    assign dc_p[0]   = num;
    assign dc_q[0]   = '0;

    for (genvar j = 0; j < NQ; j++)
    begin : g_div
        dsap_div_cell #(.NW(NW)) u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (dc_ctl[j]),
            .p_in    (dc_p[j]),
            .q_in    (dc_q[j]),
            .den     (den),
            .ctl_out (dc_ctl[j+1]),
            .p_out   (dc_p[j+1]),
            .q_out   (dc_q[j+1])
        );
    end

    assign res  = dc_ctl[NQ].zero ? '0 : dc_q[NQ];
    assign push = en && dc_ctl[NQ].vld;
    assign pop  = (cnt_reg != 2'd0) && alp.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            buf0_reg <= res;
        end
        else if (pop)
        begin
            buf0_reg <= buf1_reg;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                buf0_reg <= res;
            end
            else
            begin
                buf1_reg <= res;
            end
        end
    end

    assign alp.valid = cnt_reg != 2'd0;
    assign alp.alpha = buf0_reg;

endmodule

// ===== rtl/core/dsap_cfg.sv =====
// dsap_cfg: apb register file holding the popup geometry and falloff settings
// depends on dsap_pkg
module dsap_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsap_pkg::ADDR_W-1:0]   paddr,
    input  logic [dsap_pkg::DATA_W-1:0]   pwdata,
    output logic [dsap_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output dsap_pkg::cfg_t                cfg
);

    dsap_pkg::cfg_t                   cfg_reg;
    logic                             wr;
    logic [dsap_pkg::REG_IX_W-1:0]    ix;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ix     = paddr[dsap_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.popup_width  <= dsap_pkg::RST_POPUP_WIDTH;
            cfg_reg.popup_height <= dsap_pkg::RST_POPUP_HEIGHT;
            cfg_reg.margin       <= dsap_pkg::RST_MARGIN;
            cfg_reg.offset_x     <= dsap_pkg::RST_OFFSET_X;
            cfg_reg.offset_y     <= dsap_pkg::RST_OFFSET_Y;
            cfg_reg.radius       <= dsap_pkg::RST_RADIUS;
            cfg_reg.max_alpha    <= dsap_pkg::RST_MAX_ALPHA;
        end
        else if (wr)
        begin
            case (ix)
                dsap_pkg::REG_POPUP_WIDTH:
                    cfg_reg.popup_width <= pwdata[dsap_pkg::SIZE_W-1:0];
                dsap_pkg::REG_POPUP_HEIGHT:
                    cfg_reg.popup_height <= pwdata[dsap_pkg::SIZE_W-1:0];
                dsap_pkg::REG_MARGIN:    cfg_reg.margin    <= pwdata[dsap_pkg::BYTE_W-1:0];
                dsap_pkg::REG_OFFSET_X:  cfg_reg.offset_x  <= pwdata[dsap_pkg::BYTE_W-1:0];
                dsap_pkg::REG_OFFSET_Y:  cfg_reg.offset_y  <= pwdata[dsap_pkg::BYTE_W-1:0];
                dsap_pkg::REG_RADIUS:    cfg_reg.radius    <= pwdata[dsap_pkg::BYTE_W-1:0];
                dsap_pkg::REG_MAX_ALPHA: cfg_reg.max_alpha <= pwdata[dsap_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ix)
            dsap_pkg::REG_POPUP_WIDTH:  prdata = dsap_pkg::DATA_W'(cfg_reg.popup_width);
            dsap_pkg::REG_POPUP_HEIGHT: prdata = dsap_pkg::DATA_W'(cfg_reg.popup_height);
            dsap_pkg::REG_MARGIN:       prdata = dsap_pkg::DATA_W'(cfg_reg.margin);
            dsap_pkg::REG_OFFSET_X:     prdata = dsap_pkg::DATA_W'(cfg_reg.offset_x);
            dsap_pkg::REG_OFFSET_Y:     prdata = dsap_pkg::DATA_W'(cfg_reg.offset_y);
            dsap_pkg::REG_RADIUS:       prdata = dsap_pkg::DATA_W'(cfg_reg.radius);
            dsap_pkg::REG_MAX_ALPHA:    prdata = dsap_pkg::DATA_W'(cfg_reg.max_alpha);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/dsap_front.sv =====
// dsap_front: popup hit test and squared distance to the caster, three stages
// depends on dsap_pkg
module dsap_front #(
    parameter int MAX_COORD = 4096
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [dsap_pkg::PX_W-1:0]   px,
    input  logic [dsap_pkg::PX_W-1:0]   py,
    input  dsap_pkg::cfg_t              cfg,
    output dsap_pkg::ctl_t              ctl_out,
    output logic [dsap_pkg::SQ_W-1:0]   sq
);

    localparam int CW = dsap_pkg::CW;
    localparam int SW = CW + 1;

    function automatic logic [CW-1:0] out_dist(
        input logic [dsap_pkg::PX_W-1:0]   p,
        input logic [dsap_pkg::BYTE_W-1:0] m,
        input logic [dsap_pkg::BYTE_W-1:0] off,
        input logic [dsap_pkg::SIZE_W-1:0] len
    );
        logic signed [SW-1:0] cl;
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] mx;
        cl = $signed(SW'(m)) + $signed(SW'(off));
        a  = cl - $signed(SW'(p));
        b  = $signed(SW'(p)) + $signed(SW'(1)) - cl - $signed(SW'(len));
        mx = (a > b) ? a : b;
        out_dist = (mx < 0) ? '0 : mx[CW-1:0];
    endfunction

    logic                 vld1_reg, vld2_reg, vld3_reg;
    logic                 zero1_reg, zero2_reg, zero3_reg;
    logic [CW-1:0]        dx_reg, dy_reg;
    logic [2*CW-1:0]      dx2_reg, dy2_reg;
    logic [dsap_pkg::SQ_W-1:0] sq_reg;
    logic                 in_body;
    logic                 zero_next;

    always_comb
    begin
        in_body = (CW'(px) >= CW'(cfg.margin))
               && (CW'(px) < CW'(cfg.margin) + CW'(cfg.popup_width))
               && (CW'(py) >= CW'(cfg.margin))
               && (CW'(py) < CW'(cfg.margin) + CW'(cfg.popup_height));
        zero_next = (32'(px) >= MAX_COORD) || (32'(py) >= MAX_COORD) || in_body
                 || (cfg.radius == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero1_reg <= zero_next;
            dx_reg    <= out_dist(px, cfg.margin, cfg.offset_x, cfg.popup_width);
            dy_reg    <= out_dist(py, cfg.margin, cfg.offset_y, cfg.popup_height);
            zero2_reg <= zero1_reg;
            dx2_reg   <= dx_reg * dx_reg;
            dy2_reg   <= dy_reg * dy_reg;
            zero3_reg <= zero2_reg;
            sq_reg    <= dsap_pkg::SQ_W'(dx2_reg) + dsap_pkg::SQ_W'(dy2_reg);
        end
    end

    assign ctl_out = '{vld: vld3_reg, zero: zero3_reg};
    assign sq      = sq_reg;

endmodule

// ===== rtl/core/dsap_sqrt_cell.sv =====
// dsap_sqrt_cell: one result bit of the digit by digit square root
// depends on dsap_pkg
module dsap_sqrt_cell #(
    parameter int NB = 22
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  dsap_pkg::ctl_t       ctl_in,
    input  logic [2*NB-1:0]      rad_in,
    input  logic [NB+1:0]        rem_in,
    input  logic [NB-1:0]        root_in,
    output dsap_pkg::ctl_t       ctl_out,
    output logic [2*NB-1:0]      rad_out,
    output logic [NB+1:0]        rem_out,
    output logic [NB-1:0]        root_out
);

    logic              vld_reg, zero_reg;
    logic [2*NB-1:0]   rad_reg;
    logic [NB+1:0]     rem_reg;
    logic [NB-1:0]     root_reg;
    logic [NB+3:0]     cur;
    logic [NB+3:0]     trial;
    logic              ge;
    logic [NB+1:0]     rem_next;
    logic [NB-1:0]     root_next;

    always_comb
    begin
        cur       = {rem_in, rad_in[2*NB-1 -: 2]};
        trial     = (NB+4)'({root_in, 2'b01});
        ge        = cur >= trial;
        rem_next  = ge ? (NB+2)'(cur - trial) : cur[NB+1:0];
        root_next = {root_in[NB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= ctl_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= ctl_in.zero;
            rad_reg  <= {rad_in[2*NB-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign ctl_out  = '{vld: vld_reg, zero: zero_reg};
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== rtl/core/dsap_falloff.sv =====
// dsap_falloff: radius test and numerator max_alpha*(R-d)^2, plus divisor R^2
// depends on dsap_pkg
module dsap_falloff #(
    parameter int FRAC_BITS = 8,
    parameter int NB        = 22
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  dsap_pkg::ctl_t                 ctl_in,
    input  logic [NB-1:0]                  d,
    input  logic [dsap_pkg::BYTE_W-1:0]    radius,
    input  logic [dsap_pkg::BYTE_W-1:0]    max_alpha,
    output dsap_pkg::ctl_t                 ctl_out,
    output logic [2*(dsap_pkg::BYTE_W+FRAC_BITS)+dsap_pkg::ALPHA_W-1:0] num,
    output logic [2*(dsap_pkg::BYTE_W+FRAC_BITS)-1:0]                   den
);

    localparam int DW = dsap_pkg::BYTE_W + FRAC_BITS;
    localparam int NW = 2 * DW + dsap_pkg::ALPHA_W;

    logic                 vld1_reg, vld2_reg, vld3_reg;
    logic                 zero1_reg, zero2_reg, zero3_reg;
    logic [DW-1:0]        diff_reg;
    logic [2*DW-1:0]      dsq_reg;
    logic [NW-1:0]        num_reg;
    logic [2*DW-1:0]      den_reg;
    logic [NB-1:0]        r_full;
    logic                 over;

    always_comb
    begin
        r_full = NB'(DW'(radius) << FRAC_BITS);
        over   = d > r_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= ctl_in.vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= ((2*DW)'(radius) * (2*DW)'(radius)) << (2 * FRAC_BITS);
        if (en)
        begin
            zero1_reg <= ctl_in.zero || over;
            diff_reg  <= DW'(r_full - d);
            zero2_reg <= zero1_reg;
            dsq_reg   <= diff_reg * diff_reg;
            zero3_reg <= zero2_reg;
            num_reg   <= NW'(dsq_reg) * NW'(max_alpha);
        end
    end

    assign ctl_out = '{vld: vld3_reg, zero: zero3_reg};
    assign num     = num_reg;
    assign den     = den_reg;

endmodule

// ===== rtl/core/dsap_div_cell.sv =====
// dsap_div_cell: one quotient bit of the restoring divide num / den
// depends on dsap_pkg
module dsap_div_cell #(
    parameter int NW = 40
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  dsap_pkg::ctl_t                ctl_in,
    input  logic [NW-1:0]                 p_in,
    input  logic [dsap_pkg::ALPHA_W-1:0]  q_in,
    input  logic [NW-dsap_pkg::ALPHA_W-1:0] den,
    output dsap_pkg::ctl_t                ctl_out,
    output logic [NW-1:0]                 p_out,
    output logic [dsap_pkg::ALPHA_W-1:0]  q_out
);

    localparam int QW = dsap_pkg::ALPHA_W;

    logic              vld_reg, zero_reg;
    logic [NW-1:0]     p_reg;
    logic [QW-1:0]     q_reg;
    logic [NW-1:0]     sh;
    logic              ge;
    logic [NW-1:0]     pd;

    always_comb
    begin
        sh = NW'(den) << (QW - 1);
        ge = p_in >= sh;
        pd = ge ? p_in - sh : p_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= ctl_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= ctl_in.zero;
            p_reg    <= {pd[NW-2:0], 1'b0};
            q_reg    <= {q_in[QW-2:0], ge};
        end
    end

    assign ctl_out = '{vld: vld_reg, zero: zero_reg};
    assign p_out   = p_reg;
    assign q_out   = q_reg;

endmodule

// ===== rtl/core/dsap_checker.sv =====
// dsap_checker: port level checks of drop_shadow_alpha_pixel, bound to the top level
// depends on dsap_pkg and drop_shadow_alpha_pixel
module dsap_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [dsap_pkg::ALPHA_W-1:0]  out_alpha,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsap_pkg::ADDR_W-1:0]   paddr,
    input  logic [dsap_pkg::DATA_W-1:0]   pwdata,
    input  logic [dsap_pkg::DATA_W-1:0]   prdata,
    input  logic                          pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_alpha_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_alpha))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("buffer not empty after reset");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite
            && paddr == {dsap_pkg::REG_POPUP_WIDTH, 2'b00}
        |=> (paddr != $past(paddr))
            || (prdata == dsap_pkg::DATA_W'($past(pwdata[dsap_pkg::SIZE_W-1:0]))))
        else $error("width register readback mismatch");

endmodule

bind drop_shadow_alpha_pixel dsap_checker u_dsap_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pix.ready),
    .out_valid (alp.valid),
    .out_ready (alp.ready),
    .out_alpha (alp.alpha),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);

// ===== bench/dsap_checker.sv =====
// dsap_scoreboard: watches the pixel and alpha channels and predicts each alpha word
// depends on dsap_pkg, dsap_pix_if, dsap_alpha_if; config mirror is driven by testbench
module dsap_scoreboard
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsap_pkg::cfg_t       cfg,
    dsap_pix_if                  pix,
    dsap_alpha_if                alp,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [dsap_pkg::ALPHA_W-1:0] alpha_queue[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v)
        begin
            bt = bt >> 2;
        end
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic longint gap_outside(longint p, longint lo, longint hi_excl);
        longint a;
        longint b;
        a = lo - p;
        b = p - (hi_excl - 1);
        if (a < 0)
        begin
            a = 0;
        end
        return (b > a) ? b : a;
    endfunction

    function automatic logic [dsap_pkg::ALPHA_W-1:0] shadow_alpha(
        logic [dsap_pkg::PX_W-1:0] x,
        logic [dsap_pkg::PX_W-1:0] y);
        longint m;
        longint w;
        longint h;
        longint cl;
        longint ct;
        longint dx;
        longint dy;
        longint unsigned d;
        longint unsigned r;
        longint unsigned diff;
        m = cfg.margin;
        w = cfg.popup_width;
        h = cfg.popup_height;
        if (x >= m && x < m + w && y >= m && y < m + h)
        begin
            return '0;
        end
        if (cfg.radius == 0)
        begin
            return '0;
        end
        cl = m + cfg.offset_x;
        ct = m + cfg.offset_y;
        dx = gap_outside(x, cl, cl + w);
        dy = gap_outside(y, ct, ct + h);
        d = int_sqrt(longint'(dx * dx + dy * dy) << 16);
        r = longint'(cfg.radius) << 8;
        if (d > r)
        begin
            return '0;
        end
        diff = r - d;
        return dsap_pkg::ALPHA_W'((cfg.max_alpha * diff * diff) / (r * r));
    endfunction

    task automatic report(string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    assign pending = alpha_queue.size();

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix.valid && pix.ready)
            begin
                alpha_queue.push_back(shadow_alpha(pix.px, pix.py));
            end
            if (alp.valid && alp.ready)
            begin
                if (alpha_queue.size() == 0)
                begin
                    report($sformatf("alpha %0d with no word pending", alp.alpha));
                end
                else if (alp.alpha !== alpha_queue[0])
                begin
                    report($sformatf("alpha %0d, predicted %0d", alp.alpha, alpha_queue[0]));
                    void'(alpha_queue.pop_front());
                end
                else
                begin
                    void'(alpha_queue.pop_front());
                end
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
// testbench: stimulus, register setup and verdict for drop_shadow_alpha_pixel
// depends on dsap_pkg, dsap_pix_if, dsap_alpha_if, dsap_scoreboard and the rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dsap_pkg::ADDR_W-1:0]   paddr;
    logic [dsap_pkg::DATA_W-1:0]   pwdata;
    logic [dsap_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    dsap_pkg::cfg_t                cfg;
    int                            fail_count;
    int                            pending;
    int                            hold_cycles;
    int                            out_wait;
    bit                            random_stall;

    dsap_pix_if   pix ();
    dsap_alpha_if alp ();

    drop_shadow_alpha_pixel DUT (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pix(pix), .alp(alp)
    );

    dsap_scoreboard checker_i (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .pix(pix), .alp(alp),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic reg_write(logic [dsap_pkg::REG_IX_W-1:0] ix, int unsigned value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= dsap_pkg::ADDR_W'({ix, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (ix)
            dsap_pkg::REG_POPUP_WIDTH:  cfg.popup_width = value[dsap_pkg::SIZE_W-1:0];
            dsap_pkg::REG_POPUP_HEIGHT: cfg.popup_height = value[dsap_pkg::SIZE_W-1:0];
            dsap_pkg::REG_MARGIN:       cfg.margin = value[dsap_pkg::BYTE_W-1:0];
            dsap_pkg::REG_OFFSET_X:     cfg.offset_x = value[dsap_pkg::BYTE_W-1:0];
            dsap_pkg::REG_OFFSET_Y:     cfg.offset_y = value[dsap_pkg::BYTE_W-1:0];
            dsap_pkg::REG_RADIUS:       cfg.radius = value[dsap_pkg::BYTE_W-1:0];
            dsap_pkg::REG_MAX_ALPHA:    cfg.max_alpha = value[dsap_pkg::BYTE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic set_shape(int w, int h, int m, int ox, int oy, int r, int a);
        drain();
        reg_write(dsap_pkg::REG_POPUP_WIDTH, w);
        reg_write(dsap_pkg::REG_POPUP_HEIGHT, h);
        reg_write(dsap_pkg::REG_MARGIN, m);
        reg_write(dsap_pkg::REG_OFFSET_X, ox);
        reg_write(dsap_pkg::REG_OFFSET_Y, oy);
        reg_write(dsap_pkg::REG_RADIUS, r);
        reg_write(dsap_pkg::REG_MAX_ALPHA, a);
    endtask

    task automatic send_pixel(int x, int y, int no_gap);
        int gap;
        gap = (no_gap != 0) ? 0 : int'($urandom_range(0, 18));
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.valid <= 1'b1;
        pix.px <= dsap_pkg::PX_W'(x);
        pix.py <= dsap_pkg::PX_W'(y);
        @(posedge clk);
        while (!pix.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // random pixel mostly near the shadow band around the popup
    task automatic random_pixels(int count);
        int lim_x;
        int lim_y;
        int x;
        int y;
        lim_x = cfg.margin * 2 + cfg.popup_width + cfg.offset_x + 8;
        lim_y = cfg.margin * 2 + cfg.popup_height + cfg.offset_y + 8;
        if (lim_x > 4095) lim_x = 4095;
        if (lim_y > 4095) lim_y = 4095;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end
            else
            begin
                x = $urandom_range(0, lim_x);
                y = $urandom_range(0, lim_y);
            end
            send_pixel(x, y, int'($urandom_range(0, 3) == 0));
        end
    endtask

    always @(posedge clk)
    begin
        if (alp.valid && alp.ready)
        begin
            out_wait <= random_stall ? int'($urandom_range(0, 18)) : 0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            alp.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (out_wait > 0)
        begin
            alp.ready <= 1'b0;
            out_wait <= out_wait - 1;
        end
        else
        begin
            alp.ready <= 1'b1;
        end
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix.valid = 1'b0;
        pix.px = '0;
        pix.py = '0;
        alp.ready = 1'b0;
        hold_cycles = 0;
        out_wait = 0;
        random_stall = 1'b0;
        cfg = '{dsap_pkg::RST_POPUP_WIDTH, dsap_pkg::RST_POPUP_HEIGHT, dsap_pkg::RST_MARGIN,
                dsap_pkg::RST_OFFSET_X, dsap_pkg::RST_OFFSET_Y, dsap_pkg::RST_RADIUS,
                dsap_pkg::RST_MAX_ALPHA};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults, corners, inside popup
        send_pixel(0, 0, 0);
        send_pixel(12, 12, 0);
        send_pixel(15, 17, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(4095, 0, 0);
        send_pixel(0, 4095, 0);
        send_pixel(14, 16, 0);
        send_pixel(20, 13, 0);
        drain();

        // zero size popup, zero radius, extremes
        set_shape(0, 0, 255, 255, 255, 0, 255);
        send_pixel(255, 255, 0);
        send_pixel(600, 600, 0);
        set_shape(0, 0, 0, 0, 0, 255, 255);
        send_pixel(0, 0, 0);
        send_pixel(100, 200, 0);
        send_pixel(255, 0, 0);
        send_pixel(3000, 3000, 0);
        set_shape(4095, 4095, 255, 255, 255, 1, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(0, 0, 0);
        set_shape(3583, 3583, 255, 0, 0, 255, 255);
        send_pixel(0, 0, 0);
        send_pixel(4095, 4095, 0);
        send_pixel(3838, 300, 0);
        drain();

        random_stall = 1'b1;
        for (int phase = 0; phase < 8; phase++)
        begin
            set_shape($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
            if (phase == 3)
            begin
                hold_cycles = 600;
            end
            random_stall = (phase % 3) != 2;
            random_pixels(95);
            drain();
        end

        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
